>>> sv/tcie_pkg.sv
// ----------------------------------------------------------------------------
// tcie_pkg
// shared opcodes, flag codes, operand constants and sequencer states of the toy cpu execute block
// ----------------------------------------------------------------------------
package tcie_pkg;

  localparam logic [7:0] OP_HALT = 8'd0;
  localparam logic [7:0] OP_MOV  = 8'd1;
  localparam logic [7:0] OP_ADD  = 8'd2;
  localparam logic [7:0] OP_SUB  = 8'd3;
  localparam logic [7:0] OP_MUL  = 8'd4;
  localparam logic [7:0] OP_DIV  = 8'd5;
  localparam logic [7:0] OP_AND  = 8'd6;
  localparam logic [7:0] OP_OR   = 8'd7;
  localparam logic [7:0] OP_NOT  = 8'd8;
  localparam logic [7:0] OP_CMP  = 8'd9;
  localparam logic [7:0] OP_JMP  = 8'd10;
  localparam logic [7:0] OP_IN   = 8'd11;
  localparam logic [7:0] OP_OUT  = 8'd12;

  localparam logic [1:0] FLAG_EQ = 2'd0;
  localparam logic [1:0] FLAG_GT = 2'd1;
  localparam logic [1:0] FLAG_LT = 2'd2;

  localparam logic [3:0] SRC_IMM      = 4'd0;
  localparam logic [3:0] SRC_LAST_ST  = 4'd4;
  localparam logic [3:0] JCC_LAST     = 4'd3;
  localparam logic [15:0] IP_STEP     = 16'd4;
  localparam logic [4:0] DIV_STEPS    = 5'd16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_D,
    ST_RD_S,
    ST_ADDR,
    ST_MRD0,
    ST_MRD1,
    ST_MRD2,
    ST_MWR0,
    ST_MWR1,
    ST_EXEC,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

>>> sv/toy_cpu_instruction_execute.sv
// ----------------------------------------------------------------------------
// toy_cpu_instruction_execute
// executes one decoded instruction of a 16-bit toy isa per input beat
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_*       | in        | tuser: func; tdata: dest_index, source_select,
//            |           |   immediate, input_value
//  m_*       | out       | tdata: next_ip, halted, out_valid, out_value,
//            |           |   flag_now, div_by_zero
//  cfg_*     | in        | data: start_address (also loads the pointer)
//
//  steps: register-only ops run from accept through two register reads
//  (one read mux), execute and output load; a memory operand adds the
//  byte reads (one byte ram port, hi then lo byte), a store or a memory
//  not adds the two byte writes; div adds the steps of the restoring
//  divider; when MEM_BYTES is not a power of two the address reduction
//  adds a reciprocal multiply, a back multiply and one correcting subtract
//  reset clears registers, flag and pointer; data memory is not cleared
//  the input is not ready while an instruction is in flight; a stalled
//  result holds the sequencer in its last step
// ----------------------------------------------------------------------------
module toy_cpu_instruction_execute import tcie_pkg::*; #(
  parameter int MEM_BYTES = 32768,
  parameter int NUM_REGS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tuser,   // func
  input  logic [39:0] s_tdata,   // dest_index, source_select, immediate, input_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // next_ip, halted, out_valid, out_value, flag_now,
                                 // div_by_zero, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam int RW = $clog2(NUM_REGS);
  localparam bit IS_POW2 = (MEM_BYTES == (1 << AW));
  localparam logic [4:0] NREG = 5'(NUM_REGS);
  localparam logic [15:0] MEM_MOD = 16'(MEM_BYTES % 65536);
  localparam logic [AW-1:0] ADDR_LAST = AW'(MEM_BYTES - 1);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(MEM_BYTES));

  state_t state, state_next;

  // architectural state
  logic [15:0] regs [NUM_REGS];
  logic [1:0]  flag;
  logic [15:0] ip;

  // latched instruction
  logic [7:0]  op_q;
  logic [3:0]  d_q, s_q;
  logic [15:0] imm_q, inval_q;

  // operands and memory word
  logic [15:0] rd_q, mem_q, wdata_q;
  logic [AW-1:0] a0_q;
  logic          store_q, neg_q, dz_q;

  // address reduction modulo the memory size
  logic [15:0] addr_q, aquo_q, arem_q, ared;
  logic [47:0] aprod;
  logic [31:0] amul;

  // restoring divider, its step counter shared with the address reduction
  logic [15:0] rem, quo, dvs;
  logic [4:0]  cnt;
  logic [16:0] rem_sh;
  logic        ge;

  // read mux and memory control
  logic [3:0]  rd_idx;
  logic [15:0] rd_val;
  logic        ram_en, ram_we;
  logic [AW-1:0] ram_addr, a1;
  logic [7:0]  ram_wdata, ram_rdata;

  logic accept;
  logic need_load, need_store;
  logic [15:0] opnd, addr_w, mag_a, mag_b;
  logic        out_free;

  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  // one register read per cycle, registers beyond the file read as zero
  assign rd_idx = (state == ST_RD_D) ? d_q : s_q;
  assign rd_val = ({1'b0, rd_idx} < NREG) ? regs[rd_idx[RW-1:0]] : 16'd0;

  assign need_store = (op_q == OP_MOV) && (s_q != SRC_IMM) && (s_q <= SRC_LAST_ST);
  assign need_load  = (s_q != SRC_IMM) && !need_store &&
                      (op_q == OP_MOV || op_q == OP_ADD || op_q == OP_SUB ||
                       op_q == OP_MUL || op_q == OP_DIV || op_q == OP_AND ||
                       op_q == OP_OR  || op_q == OP_NOT || op_q == OP_CMP);
  assign addr_w = need_store ? rd_q : rd_val;
  assign a1     = (a0_q == ADDR_LAST) ? '0 : a0_q + AW'(1);
  assign opnd   = (s_q == SRC_IMM) ? imm_q : mem_q;
  assign mag_a  = rd_q[15] ? 16'(-rd_q) : rd_q;
  assign mag_b  = opnd[15] ? 16'(-opnd) : opnd;

  // quotient estimate is exact or one low, one subtract corrects it
  assign aprod = 48'(addr_q) * 48'(RECIP);
  assign amul  = 32'(aquo_q) * 32'(MEM_BYTES);
  assign ared  = (arem_q >= MEM_MOD) ? 16'(arem_q - MEM_MOD) : arem_q;

  assign rem_sh = {rem, quo[15]};
  assign ge     = rem_sh >= {1'b0, dvs};

  tcie_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = a0_q;
    ram_wdata  = wdata_q[15:8];
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_RD_D;
        end
      end
      ST_RD_D: state_next = ST_RD_S;
      ST_RD_S: begin
        if (need_load || need_store) begin
          if (IS_POW2) begin
            state_next = need_store ? ST_MWR0 : ST_MRD0;
          end else begin
            state_next = ST_ADDR;
          end
        end else begin
          state_next = ST_EXEC;
        end
      end
      ST_ADDR: begin
        if (cnt == '0) begin
          state_next = store_q ? ST_MWR0 : ST_MRD0;
        end
      end
      ST_MRD0: begin
        ram_en     = 1'b1;
        state_next = ST_MRD1;
      end
      ST_MRD1: begin
        ram_en     = 1'b1;
        ram_addr   = a1;
        state_next = ST_MRD2;
      end
      ST_MRD2: state_next = (op_q == OP_NOT) ? ST_MWR0 : ST_EXEC;
      ST_MWR0: begin
        ram_en     = 1'b1;
        ram_we     = 1'b1;
        state_next = ST_MWR1;
      end
      ST_MWR1: begin
        ram_en     = 1'b1;
        ram_we     = 1'b1;
        ram_addr   = a1;
        ram_wdata  = wdata_q[7:0];
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (op_q == OP_DIV && opnd != 16'd0) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIV: begin
        if (cnt == '0) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // architectural state and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= '0;
      end
      flag     <= FLAG_EQ;
      ip       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ip <= cfg_data;
      end
      // output beat: loaded from the last step, dropped once taken
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op_q    <= s_tuser;
            d_q     <= s_tdata[3:0];
            s_q     <= s_tdata[7:4];
            imm_q   <= s_tdata[23:8];
            inval_q <= s_tdata[39:24];
            dz_q    <= 1'b0;
          end
        end
        ST_RD_D: rd_q <= rd_val;
        ST_RD_S: begin
          wdata_q <= rd_val;
          store_q <= need_store;
          a0_q    <= addr_w[AW-1:0];
          // address reduction by reciprocal multiplication
          addr_q  <= addr_w;
          cnt     <= 5'd2;
        end
        ST_ADDR: begin
          if (cnt == 5'd2) begin
            aquo_q <= aprod[47:32];
          end else if (cnt == 5'd1) begin
            arem_q <= addr_q - amul[15:0];
          end else begin
            a0_q <= ared[AW-1:0];
          end
          if (cnt != '0) begin
            cnt <= cnt - 5'd1;
          end
        end
        ST_MRD1: mem_q[15:8] <= ram_rdata;
        ST_MRD2: begin
          mem_q[7:0] <= ram_rdata;
          wdata_q    <= ({mem_q[15:8], ram_rdata} == 16'd0) ? 16'd1 : 16'd0;
        end
        ST_EXEC: begin
          logic        wr;
          logic [15:0] res;
          logic        take;
          wr   = 1'b0;
          res  = '0;
          take = 1'b0;
          case (op_q)
            OP_MOV: begin
              wr  = !need_store;
              res = opnd;
            end
            OP_ADD: begin wr = 1'b1; res = rd_q + opnd; end
            OP_SUB: begin wr = 1'b1; res = rd_q - opnd; end
            OP_MUL: begin wr = 1'b1; res = 16'(rd_q * opnd); end
            OP_AND: begin wr = 1'b1; res = {15'd0, (rd_q != 0) && (opnd != 0)}; end
            OP_OR:  begin wr = 1'b1; res = {15'd0, (rd_q != 0) || (opnd != 0)}; end
            OP_NOT: begin wr = (s_q == SRC_IMM); res = {15'd0, rd_q == 0}; end
            OP_IN:  begin wr = 1'b1; res = inval_q; end
            OP_CMP: begin
              if (rd_q == opnd) begin
                flag <= FLAG_EQ;
              end else if ($signed(rd_q) > $signed(opnd)) begin
                flag <= FLAG_GT;
              end else begin
                flag <= FLAG_LT;
              end
            end
            OP_JMP: take = (s_q == SRC_IMM) ||
                           (s_q <= JCC_LAST && {2'b00, flag} == s_q - 4'd1);
            OP_DIV: begin
              dz_q <= (opnd == 16'd0);
              neg_q <= rd_q[15] ^ opnd[15];
              rem  <= '0;
              quo  <= mag_a;
              dvs  <= mag_b;
              cnt  <= DIV_STEPS;
            end
            default: ;
          endcase
          if (wr && ({1'b0, d_q} < NREG)) begin
            regs[d_q[RW-1:0]] <= res;
          end
          ip <= ip + (take ? imm_q : IP_STEP);
        end
        ST_DIV: begin
          if (cnt != '0) begin
            rem <= ge ? 16'(rem_sh - {1'b0, dvs}) : rem_sh[15:0];
            quo <= {quo[14:0], ge};
            cnt <= cnt - 5'd1;
          end else if ({1'b0, d_q} < NREG) begin
            regs[d_q[RW-1:0]] <= neg_q ? 16'(-quo) : quo;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_tdata[15:0]  <= ip;
            m_tdata[16]    <= (op_q == OP_HALT);
            m_tdata[17]    <= (op_q == OP_OUT);
            m_tdata[33:18] <= (op_q == OP_OUT) ? rd_q : 16'd0;
            m_tdata[35:34] <= flag;
            m_tdata[36]    <= dz_q;
            m_tdata[39:37] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // one instruction at a time: no second accept right after the first
  assert property (@(posedge clk) disable iff (rst) accept |=> !s_tready)
    else $error("input accepted while an instruction is in flight");

  // the compare flag never takes the unused code
  assert property (@(posedge clk) disable iff (rst) flag != 2'd3)
    else $error("compare flag holds an unused code");

  // the divider counter never runs past its step count
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV || state == ST_ADDR) |-> cnt <= DIV_STEPS)
    else $error("divider step count out of range");

  // a result is only loaded when the output register is free
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && m_tvalid && !m_tready) |=> state == ST_DONE)
    else $error("sequencer left the result step while the output stalled");

endmodule

>>> sv/tcie_ram.sv
// ----------------------------------------------------------------------------
// tcie_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module tcie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule
